@@ hw/rtl/bmb_pkg.sv @@
package bmb_pkg;

	// matrix geometry
	localparam int ELEM_COUNT = 16;
	localparam int POS_W      = 4;
	localparam int BONE_W     = 8;
	localparam int WGT_W      = 16;
	localparam int ELEM_W     = 32;
	localparam int LANES      = 4;

	// arithmetic widths: Q16.16 x Q1.15 product, sum of four products
	localparam int PROD_W     = ELEM_W + WGT_W + 1;
	localparam int SUM_W      = PROD_W + 2;
	localparam int FRAC_SHIFT = 15;
	localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

	localparam logic [WGT_W-1:0]  WEIGHT_ONE = 16'h8000;
	localparam logic [WGT_W-1:0]  WEIGHT_NIL = 16'h0000;
	localparam logic [POS_W-1:0]  POS_LAST   = 4'hF;
	localparam logic [ELEM_W-1:0] ELEM_MAX   = 32'h7FFF_FFFF;
	localparam logic [ELEM_W-1:0] ELEM_MIN   = 32'h8000_0000;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_COPY   = 2'd1,
		KIND_BLEND2 = 2'd2,
		KIND_BLEND4 = 2'd3
	} kind_t;

	// one palette read slot handed from the sequencer to the datapath
	typedef struct packed {
		logic                         valid;
		logic [POS_W-1:0]             pos;
		logic [LANES-1:0]             take;
		logic [LANES-1:0][WGT_W-1:0]  wgt;
	} issue_t;

endpackage

@@ hw/rtl/bmb_item_if.sv @@
interface bmb_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [7:0]         bone_index_0;
	logic [7:0]         bone_index_1;
	logic [7:0]         bone_index_2;
	logic [7:0]         bone_index_3;
	logic [15:0]        weight_0;
	logic [15:0]        weight_1;
	logic [15:0]        weight_2;
	logic [15:0]        weight_3;
	logic [3:0]         element_slot;
	logic signed [31:0] element_value;

	modport source (
		output valid, kind, bone_index_0, bone_index_1, bone_index_2, bone_index_3,
		output weight_0, weight_1, weight_2, weight_3, element_slot, element_value,
		input  ready
	);

	modport sink (
		input  valid, kind, bone_index_0, bone_index_1, bone_index_2, bone_index_3,
		input  weight_0, weight_1, weight_2, weight_3, element_slot, element_value,
		output ready
	);
endinterface

@@ hw/rtl/bmb_result_if.sv @@
interface bmb_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] blended_element;
	logic [3:0]         element_position;
	logic               last_element;

	modport source (
		output valid, blended_element, element_position, last_element,
		input  ready
	);

	modport sink (
		input  valid, blended_element, element_position, last_element,
		output ready
	);
endinterface

@@ hw/rtl/bmb_ram.sv @@
module bmb_ram #(
	parameter  int DEPTH = 4096,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [31:0]   rd_data0,
	output logic [31:0]   rd_data1
);
	logic [31:0] mem [DEPTH];
	logic [31:0] rd0_q;
	logic [31:0] rd1_q;

	// one write port, two registered read ports, read-before-write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd0_q <= mem[raddr0];
			rd1_q <= mem[raddr1];
		end
	end

	assign rd_data0 = rd0_q;
	assign rd_data1 = rd1_q;
endmodule

@@ hw/rtl/bmb_seq.sv @@
module bmb_seq #(
	parameter  int BONE_COUNT = 256,
	localparam int AW         = $clog2(BONE_COUNT * 16)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bmb_item_if.sink              items,
	input  logic                  adv,
	output bmb_pkg::issue_t       issue,
	output logic [3:0][AW-1:0]    raddr,
	output logic                  wen,
	output logic [AW-1:0]         waddr,
	output logic [31:0]           wdata
);
	import bmb_pkg::*;

	localparam int               LIM_W      = 13;
	localparam logic [LIM_W-1:0] BONE_LIMIT = LIM_W'(BONE_COUNT);

	logic                          busy_q;
	logic [POS_W-1:0]              pos_q;
	logic [LANES-1:0][BONE_W-1:0]  bone_q;
	logic [LANES-1:0]              take_q;
	logic [LANES-1:0][WGT_W-1:0]   wgt_q;

	kind_t                         kind;
	logic                          is_load;
	logic                          acc;
	logic                          last_issue;
	logic [LANES-1:0][BONE_W-1:0]  bone_in;
	logic [LANES-1:0]              in_range;
	logic [LANES-1:0]              kind_mask;
	logic [LANES-1:0][WGT_W-1:0]   wgt_in;

	function automatic logic [AW-1:0] mk_addr(input logic [BONE_W-1:0] bone,
		input logic [POS_W-1:0] pos);
		logic [15:0] full;
		full = {4'b0, bone, pos};
		return full[AW-1:0];
	endfunction

	// request decode: lanes in use and their weights
	always_comb begin
		kind    = kind_t'(items.kind);
		is_load = (kind == KIND_LOAD);
		bone_in = {items.bone_index_3, items.bone_index_2,
			items.bone_index_1, items.bone_index_0};
		for (int k = 0; k < LANES; k++) begin
			in_range[k] = {5'b0, bone_in[k]} < BONE_LIMIT;
		end
		case (kind)
			KIND_COPY: begin
				kind_mask = 4'b0001;
				wgt_in    = {WEIGHT_NIL, WEIGHT_NIL, WEIGHT_NIL, WEIGHT_ONE};
			end
			KIND_BLEND2: begin
				kind_mask = 4'b0011;
				wgt_in    = {WEIGHT_NIL, WEIGHT_NIL, items.weight_1, items.weight_0};
			end
			KIND_BLEND4: begin
				kind_mask = 4'b1111;
				wgt_in    = {items.weight_3, items.weight_2, items.weight_1, items.weight_0};
			end
			default: begin
				kind_mask = 4'b0000;
				wgt_in    = {WEIGHT_NIL, WEIGHT_NIL, WEIGHT_NIL, WEIGHT_NIL};
			end
		endcase
	end

	// next request is taken on the cycle of the last palette read
	assign last_issue  = busy_q && adv && (pos_q == POS_LAST);
	assign items.ready = !busy_q || last_issue;
	assign acc         = items.valid && items.ready;

	// palette load port
	assign wen   = acc && is_load && in_range[0];
	assign waddr = mk_addr(items.bone_index_0, items.element_slot);
	assign wdata = items.element_value;

	// element counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (busy_q && adv) begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == POS_LAST) begin
					busy_q <= 1'b0;
				end
			end
			if (acc && !is_load) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end
		end
	end

	// blend request hold
	always_ff @(posedge clk) begin
		if (acc && !is_load) begin
			bone_q <= bone_in;
			take_q <= in_range & kind_mask;
			wgt_q  <= wgt_in;
		end
	end

	// read addresses and slot info for the datapath
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			raddr[k] = mk_addr(bone_q[k], pos_q);
		end
		issue.valid = busy_q;
		issue.pos   = pos_q;
		issue.take  = take_q;
		issue.wgt   = wgt_q;
	end
endmodule

@@ hw/rtl/bmb_mac.sv @@
module bmb_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  bmb_pkg::issue_t   issue,
	input  logic [3:0][31:0]  rd_data,
	output logic              adv,
	bmb_result_if.source      results
);
	import bmb_pkg::*;

	logic                     v_s1, v_s2, v_s3, v_s4;
	issue_t                   iss_s1;
	logic signed [PROD_W-1:0] prod_s2 [LANES];
	logic [POS_W-1:0]         pos_s2, pos_s3, pos_s4;
	logic signed [SUM_W-1:0]  sum_a_s3, sum_b_s3;
	logic [ELEM_W-1:0]        res_s4;

	logic signed [ELEM_W-1:0] elem [LANES];
	logic signed [PROD_W-1:0] prod_nx [LANES];
	logic signed [SUM_W-1:0]  sum_a_nx, sum_b_nx;
	logic signed [SUM_W-1:0]  total;
	logic signed [SUM_W-1:0]  shifted;
	logic [SUM_W-32:0]        upper;
	logic [ELEM_W-1:0]        res_nx;

	// whole pipe moves when the result register is free
	assign adv = !v_s4 || results.ready;

	// weighted products, unused lanes forced to zero
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			elem[k]    = iss_s1.take[k] ? $signed(rd_data[k]) : '0;
			prod_nx[k] = PROD_W'(elem[k]) * $signed({{(PROD_W-WGT_W){1'b0}}, iss_s1.wgt[k]});
		end
	end

	// pair sums, rounding half folded into the first
	assign sum_a_nx = SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1]) + SUM_W'(ROUND_HALF);
	assign sum_b_nx = SUM_W'(prod_s2[2]) + SUM_W'(prod_s2[3]);

	// final sum, floor shift to Q16.16 and saturation
	always_comb begin
		total   = sum_a_s3 + sum_b_s3;
		shifted = total >>> FRAC_SHIFT;
		upper   = shifted[SUM_W-1:31];
		if ((&upper) || !(|upper)) begin
			res_nx = shifted[ELEM_W-1:0];
		end else if (shifted[SUM_W-1]) begin
			res_nx = ELEM_MIN;
		end else begin
			res_nx = ELEM_MAX;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			iss_s1   <= issue;
			prod_s2  <= prod_nx;
			pos_s2   <= iss_s1.pos;
			sum_a_s3 <= sum_a_nx;
			sum_b_s3 <= sum_b_nx;
			pos_s3   <= pos_s2;
			res_s4   <= res_nx;
			pos_s4   <= pos_s3;
		end
	end

	assign results.valid            = v_s4;
	assign results.blended_element  = res_s4;
	assign results.element_position = pos_s4;
	assign results.last_element     = (pos_s4 == POS_LAST);
endmodule

@@ hw/rtl/bone_matrix_blend_top.sv @@
// bone matrix blend: linear blend skinning over a palette of 4x4 Q16.16 matrices
//
// items (sink): a load request writes one palette element and gives no result;
// a copy, two-bone or four-bone request gives sixteen results on the results
// channel (source), row-major, last_element set on position fifteen.
// a load request does not hold off the next one. for a blend the palette is
// held twice, each copy with two read ports, so the four bones of one element
// are read in the same cycle and one element is issued per cycle while results
// do not stall; the next request is taken on the cycle of the sixteenth read.
// the first result of a blend passes the request hold register, then the read,
// multiply, pair add and final add with round and saturate stages.
// a stall on results freezes the whole pipe; the reads stop and a request
// behind a running blend waits until the pipe moves again.
// reset empties the pipe and the sequencer; the palette itself is not cleared
// and an entry must be loaded before a blend reads it.
// bones at or above BONE_COUNT read as zero and loads to them are dropped.
module bone_matrix_blend_top #(
	parameter int BONE_COUNT = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	bmb_item_if.sink      items,
	bmb_result_if.source  results
);
	import bmb_pkg::*;

	localparam int DEPTH = BONE_COUNT * ELEM_COUNT;
	localparam int AW    = $clog2(DEPTH);

	issue_t                 issue;
	logic [3:0][AW-1:0]     raddr;
	logic [3:0][31:0]       rd_data;
	logic                   wen;
	logic [AW-1:0]          waddr;
	logic [31:0]            wdata;
	logic                   adv;

	// request sequencer and palette addressing
	bmb_seq #(.BONE_COUNT(BONE_COUNT)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.adv    (adv),
		.issue  (issue),
		.raddr  (raddr),
		.wen    (wen),
		.waddr  (waddr),
		.wdata  (wdata)
	);

	// palette copy for bones zero and one
	bmb_ram #(.DEPTH(DEPTH)) u_ram_lo (
		.clk      (clk),
		.we       (wen),
		.waddr    (waddr),
		.wdata    (wdata),
		.re       (adv),
		.raddr0   (raddr[0]),
		.raddr1   (raddr[1]),
		.rd_data0 (rd_data[0]),
		.rd_data1 (rd_data[1])
	);

	// palette copy for bones two and three
	bmb_ram #(.DEPTH(DEPTH)) u_ram_hi (
		.clk      (clk),
		.we       (wen),
		.waddr    (waddr),
		.wdata    (wdata),
		.re       (adv),
		.raddr0   (raddr[2]),
		.raddr1   (raddr[3]),
		.rd_data0 (rd_data[2]),
		.rd_data1 (rd_data[3])
	);

	// weighting, summing and result register
	bmb_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue),
		.rd_data (rd_data),
		.adv     (adv),
		.results (results)
	);
endmodule

@@ tb/bone_matrix_blend_top_tb.sv @@
`timescale 1ns / 100ps

module bone_matrix_blend_top_tb;
	import bmb_pkg::*;

	// a palette smaller than the index range, so that bones 240..255 read as zero
	localparam int BONE_COUNT     = 240;
	localparam int REQUEST_TARGET = 220;
	localparam int HOLD_CYCLES    = 150;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct {
		kind_t                        kind;
		logic [LANES-1:0][BONE_W-1:0] bone;
		logic [LANES-1:0][WGT_W-1:0]  wgt;
		logic [POS_W-1:0]             slot;
		logic signed [ELEM_W-1:0]     value;
	} bone_request_t;

	typedef struct {
		logic signed [ELEM_W-1:0] elem;
		logic [POS_W-1:0]         pos;
		logic                     last;
	} matrix_element_t;

	// palette copy and the queue of matrix elements still owed by the block
	class skin_tracker;
		logic signed [ELEM_W-1:0] palette_copy [256][ELEM_COUNT];
		matrix_element_t          due_elements [$];
		int                       bone_limit;
		int                       faults;

		function new(int bone_limit);
			this.bone_limit = bone_limit;
			faults = 0;
			foreach (palette_copy[b, p])
				palette_copy[b][p] = '0;
		endfunction

		function logic signed [ELEM_W-1:0] element_at(logic [BONE_W-1:0] bone, int p);
			if (bone >= bone_limit)
				return '0;
			return palette_copy[bone][p];
		endfunction

		// loads update the palette; blends owe sixteen elements
		function void note_request(bone_request_t r);
			int              lanes;
			longint          acc;
			longint          rounded;
			matrix_element_t e;
			if (r.kind == KIND_LOAD) begin
				if (r.bone[0] < bone_limit)
					palette_copy[r.bone[0]][r.slot] = r.value;
				return;
			end
			lanes = (r.kind == KIND_COPY) ? 1 : (r.kind == KIND_BLEND2) ? 2 : LANES;
			for (int p = 0; p < ELEM_COUNT; p++) begin
				if (lanes == 1) begin
					e.elem = element_at(r.bone[0], p);
				end else begin
					acc = 0;
					for (int k = 0; k < lanes; k++)
						acc += longint'(element_at(r.bone[k], p)) * longint'(r.wgt[k]);
					// round half up, then clamp to the q16.16 range
					rounded = (acc + ROUND_HALF) >>> FRAC_SHIFT;
					if (rounded > longint'($signed(ELEM_MAX)))
						rounded = longint'($signed(ELEM_MAX));
					if (rounded < longint'($signed(ELEM_MIN)))
						rounded = longint'($signed(ELEM_MIN));
					e.elem = rounded[ELEM_W-1:0];
				end
				e.pos  = p[POS_W-1:0];
				e.last = (e.pos == POS_LAST);
				due_elements.push_back(e);
			end
		endfunction

		function void check_element(logic signed [ELEM_W-1:0] elem, logic [POS_W-1:0] pos,
				logic last);
			matrix_element_t want;
			if (due_elements.size() == 0) begin
				$display("%0t: unexpected result, element %0d position %0d", $time, elem, pos);
				faults++;
				return;
			end
			want = due_elements.pop_front();
			if (elem !== want.elem) begin
				$display("%0t: blended_element expected %0d actual %0d", $time, want.elem, elem);
				faults++;
			end
			if (pos !== want.pos) begin
				$display("%0t: element_position expected %0d actual %0d", $time, want.pos, pos);
				faults++;
			end
			if (last !== want.last) begin
				$display("%0t: last_element expected %0b actual %0b", $time, want.last, last);
				faults++;
			end
		endfunction

		function int outstanding();
			return due_elements.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	bit           steady;
	bit           hold_results;
	int           sent_count;
	bit [15:0]    loaded_slots [256];
	int           ready_bones [$];
	skin_tracker  tracker = new(BONE_COUNT);

	bmb_item_if   items_if ();
	bmb_result_if results_if ();

	bone_matrix_blend_top #(
		.BONE_COUNT(BONE_COUNT)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#200000;
		$display("FAIL bone_matrix_blend_top");
		$finish;
	end

	// corner values for palette elements
	function automatic logic [ELEM_W-1:0] edge_value(int i);
		case (i)
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			4:       return 32'h0000_0001;
			5:       return 32'h0001_0000;
			6:       return 32'hFFFF_0000;
			7:       return 32'h0000_8000;
			8:       return 32'h0000_4000;
			9:       return 32'h8000_0001;
			10:      return 32'h7FFF_0000;
			11:      return 32'h1234_5678;
			12:      return 32'hEDCB_A988;
			13:      return 32'h0000_0002;
			14:      return 32'hFFFF_FFFE;
			default: return 32'h5555_AAAA;
		endcase
	endfunction

	function automatic logic [ELEM_W-1:0] random_value();
		if ($urandom_range(3) == 0)
			return edge_value($urandom_range(15));
		return $urandom();
	endfunction

	// mostly at most one, some above one, some exactly zero or one
	function automatic logic [WGT_W-1:0] random_weight();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return pick[0] ? WEIGHT_ONE : WEIGHT_NIL;
		if (pick < 30)
			return WGT_W'($urandom_range(65535));
		return WGT_W'($urandom_range(32768));
	endfunction

	// a bone that is safe to read: fully loaded, or beyond the palette
	function automatic logic [BONE_W-1:0] readable_bone();
		if (ready_bones.size() == 0 || $urandom_range(9) == 0)
			return BONE_W'($urandom_range(255, BONE_COUNT));
		return BONE_W'(ready_bones[$urandom_range(ready_bones.size() - 1)]);
	endfunction

	function automatic void mark_loaded(logic [BONE_W-1:0] bone, logic [POS_W-1:0] slot);
		if (bone >= BONE_COUNT || loaded_slots[bone] == 16'hFFFF)
			return;
		loaded_slots[bone][slot] = 1'b1;
		if (loaded_slots[bone] == 16'hFFFF)
			ready_bones.push_back(int'(bone));
	endfunction

	// load request; unused fields carry random bits
	function automatic bone_request_t load_request(logic [BONE_W-1:0] bone,
			logic [POS_W-1:0] slot, logic [ELEM_W-1:0] value);
		bone_request_t r;
		r.kind  = KIND_LOAD;
		for (int k = 0; k < LANES; k++) begin
			r.bone[k] = BONE_W'($urandom_range(255));
			r.wgt[k]  = WGT_W'($urandom_range(65535));
		end
		r.bone[0] = bone;
		r.slot    = slot;
		r.value   = value;
		return r;
	endfunction

	function automatic bone_request_t blend_request(kind_t kind,
			logic [LANES-1:0][BONE_W-1:0] bones, logic [LANES-1:0][WGT_W-1:0] wgts);
		bone_request_t r;
		r      = load_request(bones[0], POS_W'($urandom_range(15)), $urandom());
		r.kind = kind;
		r.bone = bones;
		r.wgt  = wgts;
		return r;
	endfunction

	function automatic bone_request_t random_blend();
		bone_request_t r;
		int            lanes;
		r      = load_request(BONE_W'($urandom_range(255)), POS_W'($urandom_range(15)),
			$urandom());
		r.kind = kind_t'($urandom_range(3, 1));
		lanes  = (r.kind == KIND_COPY) ? 1 : (r.kind == KIND_BLEND2) ? 2 : LANES;
		for (int k = 0; k < LANES; k++)
			r.wgt[k] = random_weight();
		for (int k = 0; k < lanes; k++)
			r.bone[k] = readable_bone();
		return r;
	endfunction

	// offer one request from a falling edge until it is taken
	task automatic send_request(bone_request_t r);
		while (!steady && $urandom_range(99) < 6) begin
			items_if.valid <= 1'b0;
			@(negedge clk);
		end
		items_if.valid         <= 1'b1;
		items_if.kind          <= r.kind;
		items_if.bone_index_0  <= r.bone[0];
		items_if.bone_index_1  <= r.bone[1];
		items_if.bone_index_2  <= r.bone[2];
		items_if.bone_index_3  <= r.bone[3];
		items_if.weight_0      <= r.wgt[0];
		items_if.weight_1      <= r.wgt[1];
		items_if.weight_2      <= r.wgt[2];
		items_if.weight_3      <= r.wgt[3];
		items_if.element_slot  <= r.slot;
		items_if.element_value <= r.value;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		tracker.note_request(r);
		if (r.kind == KIND_LOAD)
			mark_loaded(r.bone[0], r.slot);
		sent_count++;
		if (sent_count == 100)
			hold_results = 1'b1;
		steady = (sent_count >= 140 && sent_count < 180);
		@(negedge clk);
	endtask

	// sixteen loads of one bone, starting at a random slot
	task automatic fill_bone(logic [BONE_W-1:0] bone);
		int start;
		start = $urandom_range(15);
		for (int i = 0; i < ELEM_COUNT; i++)
			send_request(load_request(bone, 4'(start + i), random_value()));
	endtask

	// result side: random stalls plus one long hold-off
	initial begin
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end
			results_if.ready <= steady || ($urandom_range(99) >= 6);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			tracker.check_element(results_if.blended_element, results_if.element_position,
				results_if.last_element);
	end

	// request stimulus
	initial begin
		int pick;
		bit paused;
		items_if.valid         = 1'b0;
		items_if.kind          = KIND_LOAD;
		items_if.bone_index_0  = '0;
		items_if.bone_index_1  = '0;
		items_if.bone_index_2  = '0;
		items_if.bone_index_3  = '0;
		items_if.weight_0      = '0;
		items_if.weight_1      = '0;
		items_if.weight_2      = '0;
		items_if.weight_3      = '0;
		items_if.element_slot  = '0;
		items_if.element_value = '0;
		arst_n       = 1'b0;
		steady       = 1'b0;
		hold_results = 1'b0;
		sent_count   = 0;
		paused       = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// bone 0 holds the corner values; a load beyond the palette is dropped
		for (int s = 0; s < ELEM_COUNT; s++)
			send_request(load_request(8'd0, s[POS_W-1:0], edge_value(s)));
		send_request(load_request(8'd250, 4'hF, 32'h5555_5555));

		// copies, saturating sums, zero weights, ties and bones beyond the palette
		send_request(blend_request(KIND_COPY, {8'd9, 8'd9, 8'd9, 8'd0}, {4{16'hFFFF}}));
		send_request(blend_request(KIND_COPY, {8'd0, 8'd0, 8'd0, 8'd255}, {4{16'h8000}}));
		send_request(blend_request(KIND_BLEND2, {8'd7, 8'd7, 8'd0, 8'd0},
			{16'hFFFF, 16'hFFFF, WEIGHT_ONE, WEIGHT_ONE}));
		send_request(blend_request(KIND_BLEND2, {8'd7, 8'd7, 8'd255, 8'd0},
			{WEIGHT_NIL, WEIGHT_NIL, 16'hFFFF, 16'hFFFF}));
		send_request(blend_request(KIND_BLEND4, {8'd0, 8'd0, 8'd0, 8'd0}, {4{16'hFFFF}}));
		send_request(blend_request(KIND_BLEND4, {8'd0, 8'd0, 8'd0, 8'd0}, {4{WEIGHT_NIL}}));
		send_request(blend_request(KIND_BLEND2, {8'd3, 8'd3, 8'd255, 8'd0},
			{16'hFFFF, 16'hFFFF, WEIGHT_NIL, 16'h4000}));
		send_request(blend_request(KIND_BLEND4, {8'd0, 8'd0, 8'd250, 8'd0},
			{16'h0001, 16'h7FFF, WEIGHT_ONE, 16'h4000}));

		// random mix, mostly blends over loaded bones
		while (sent_count < REQUEST_TARGET) begin
			if (!paused && sent_count >= 60) begin
				items_if.valid <= 1'b0;
				@(negedge clk);
				while (tracker.outstanding() != 0)
					@(negedge clk);
				paused = 1'b1;
			end
			pick = $urandom_range(99);
			if (ready_bones.size() < 3 || pick < 6) begin
				fill_bone(BONE_W'($urandom_range(255)));
			end else if (pick < 18) begin
				send_request(load_request(
					pick < 14 ? readable_bone() : BONE_W'($urandom_range(255)),
					POS_W'($urandom_range(15)), random_value()));
			end else begin
				send_request(random_blend());
			end
		end

		// drain
		items_if.valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (tracker.faults == 0)
			$display("PASS bone_matrix_blend_top");
		else
			$display("FAIL bone_matrix_blend_top");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/bmb_pkg.sv
hw/rtl/bmb_item_if.sv
hw/rtl/bmb_result_if.sv
hw/rtl/bmb_ram.sv
hw/rtl/bmb_seq.sv
hw/rtl/bmb_mac.sv
hw/rtl/bone_matrix_blend_top.sv
tb/bone_matrix_blend_top_tb.sv
